// ----- sv/ntp_cod_pkg.sv -----
// shared constants and types for the ntp clock offset and delay block
// no dependencies; used by ntp_cod_ts_conv and ntp_clock_offset_delay
`default_nettype none

package ntp_cod_pkg;

    // field widths
    localparam int SEC_W  = 32;
    localparam int FRAC_W = 32;
    localparam int US_W   = 64;
    localparam int MUL_W  = 20;
    localparam int PROD_W = SEC_W + MUL_W;

    // microseconds per second, fits in 20 bits
    localparam logic [MUL_W-1:0] US_PER_SECOND = 20'd1000000;

    // seconds from the 1900 era to the unix epoch
    localparam logic [SEC_W-1:0] EPOCH_RESET = 32'd2208988800;

    // stage enables for the timestamp converter
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
    } t_conv_ctrl;

endpackage

`default_nettype wire

// ----- sv/ntp_cod_ts_conv.sv -----
// three-stage timestamp converter: ntp seconds and fraction to microseconds
// depends on ntp_cod_pkg
`default_nettype none

module ntp_cod_ts_conv (
    input  wire                                i_clk,
    input  wire ntp_cod_pkg::t_conv_ctrl       i_ctrl,
    input  wire  [ntp_cod_pkg::SEC_W-1:0]      i_epoch,
    input  wire  [ntp_cod_pkg::SEC_W-1:0]      i_seconds,
    input  wire  [ntp_cod_pkg::FRAC_W-1:0]     i_fraction,
    output logic [ntp_cod_pkg::US_W-1:0]       o_us
);

    localparam int PW = ntp_cod_pkg::PROD_W;

    logic [ntp_cod_pkg::SEC_W-1:0]  r_whole;
    logic [ntp_cod_pkg::FRAC_W-1:0] r_frac;
    logic [PW-1:0]                  r_whole_us;
    logic [ntp_cod_pkg::MUL_W-1:0]  r_frac_us;
    logic [ntp_cod_pkg::US_W-1:0]   r_us;

    logic [PW-1:0] n_whole_us;
    logic [PW-1:0] n_frac_prod;
    logic [ntp_cod_pkg::US_W-1:0] n_us;

    // stage 1: seconds relative to the local epoch, wrapping in 32 bits
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s1) begin
            r_whole <= i_seconds - i_epoch;
            r_frac  <= i_fraction;
        end
    end

    // stage 2: scale seconds and fraction by one million
    assign n_whole_us  = {{ntp_cod_pkg::MUL_W{1'b0}}, r_whole}
                       * {{ntp_cod_pkg::SEC_W{1'b0}}, ntp_cod_pkg::US_PER_SECOND};
    assign n_frac_prod = {{ntp_cod_pkg::MUL_W{1'b0}}, r_frac}
                       * {{ntp_cod_pkg::FRAC_W{1'b0}}, ntp_cod_pkg::US_PER_SECOND};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s2) begin
            r_whole_us <= n_whole_us;
            r_frac_us  <= n_frac_prod[PW-1:ntp_cod_pkg::FRAC_W];
        end
    end

    // stage 3: whole plus fractional microseconds
    assign n_us = {{(ntp_cod_pkg::US_W-PW){1'b0}}, r_whole_us}
                + {{(ntp_cod_pkg::US_W-ntp_cod_pkg::MUL_W){1'b0}}, r_frac_us};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s3) begin
            r_us <= n_us;
        end
    end

    assign o_us = r_us;

endmodule

`default_nettype wire

// ----- sv/ntp_clock_offset_delay.sv -----
// top level of the ntp clock offset and round-trip delay block
// depends on ntp_cod_pkg and ntp_cod_ts_conv
//
// usage:
//   slave stream s_axis carries one ntp reply per beat: originate, receive
//   and transmit timestamps (32-bit seconds and fraction each) and the local
//   arrival time in microseconds. master stream m_axis returns one beat per
//   reply: clock offset, round-trip delay, server time and update time, all
//   in microseconds. the user writes the epoch register through i_cfg_we and
//   i_cfg_wdata only while no reply is in flight; not enforced by the block.
// pipeline and throughput:
//   a beat accepted by s_axis passes through the six-stage register pipeline
//   (epoch subtract, multiply by one million, microsecond add, differences,
//   sums, halving), the first stage loaded at the accepting edge; one beat per
//   cycle sustained while m_axis_tready stays high.
// reset and stall:
//   reset empties the pipeline and loads the epoch register with the 1900 to
//   1970 offset. each stage holds its beat while the stage after it is full
//   and stalled, so a stalled receiver fills bubbles first and then drops
//   s_axis_tready; nothing is lost or repeated. the output register holds
//   the latest result.
`default_nettype none

module ntp_clock_offset_delay #(
    parameter logic [ntp_cod_pkg::SEC_W-1:0] EPOCH_INIT = ntp_cod_pkg::EPOCH_RESET
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata,
    // reply stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // t1 seconds, t1 fraction, t2 seconds, t2 fraction,
    // t3 seconds, t3 fraction, arrival time in us (low bits first)
    input  wire  [255:0] s_axis_tdata,
    // result stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // offset_us, round_trip_us, server_time_us, update_time_us (low bits first)
    output logic [255:0] m_axis_tdata
);

    localparam int NSTG = 6;
    localparam int UW   = ntp_cod_pkg::US_W;

    logic [ntp_cod_pkg::SEC_W-1:0] r_epoch;
    logic [NSTG-1:0]               r_v;
    logic [NSTG-1:0]               w_rdy;
    ntp_cod_pkg::t_conv_ctrl       w_ctrl;

    logic [UW-1:0] w_t1, w_t2, w_t3;
    logic [UW-1:0] r_t4_s1, r_t4_s2, r_t4_s3;
    logic [UW-1:0] r_d21, r_d34, r_d41, r_d32, r_t3_s4, r_t4_s4;
    logic [UW-1:0] r_sum, r_rtt, r_t3_s5, r_t4_s5;
    logic [UW-1:0] r_offset, r_rtt_o, r_t3_o, r_t4_o;
    logic [UW-1:0] n_sum_adj;

    // epoch register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_INIT;
        end else if (i_cfg_we) begin
            r_epoch <= i_cfg_wdata;
        end
    end

    // per-stage ready: a stage loads when empty or when its successor moves
    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_ctrl.en_s1 = w_rdy[0];
    assign w_ctrl.en_s2 = w_rdy[1];
    assign w_ctrl.en_s3 = w_rdy[2];

    // timestamp converters, stages 1 to 3
    ntp_cod_ts_conv u_conv_t1 (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_epoch    (r_epoch),
        .i_seconds  (s_axis_tdata[31:0]),
        .i_fraction (s_axis_tdata[63:32]),
        .o_us       (w_t1)
    );

    ntp_cod_ts_conv u_conv_t2 (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_epoch    (r_epoch),
        .i_seconds  (s_axis_tdata[95:64]),
        .i_fraction (s_axis_tdata[127:96]),
        .o_us       (w_t2)
    );

    ntp_cod_ts_conv u_conv_t3 (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_epoch    (r_epoch),
        .i_seconds  (s_axis_tdata[159:128]),
        .i_fraction (s_axis_tdata[191:160]),
        .o_us       (w_t3)
    );

    // arrival time delay line alongside the converters
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_t4_s1 <= s_axis_tdata[255:192];
        if (w_rdy[1]) r_t4_s2 <= r_t4_s1;
        if (w_rdy[2]) r_t4_s3 <= r_t4_s2;
    end

    // stage 4: pairwise differences
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_d21   <= w_t2 - w_t1;
            r_d34   <= w_t3 - r_t4_s3;
            r_d41   <= r_t4_s3 - w_t1;
            r_d32   <= w_t3 - w_t2;
            r_t3_s4 <= w_t3;
            r_t4_s4 <= r_t4_s3;
        end
    end

    // stage 5: offset sum and round-trip delay
    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_sum   <= r_d21 + r_d34;
            r_rtt   <= r_d41 - r_d32;
            r_t3_s5 <= r_t3_s4;
            r_t4_s5 <= r_t4_s4;
        end
    end

    // stage 6: halve toward zero by biasing negative sums by one
    assign n_sum_adj = r_sum + {{(UW-1){1'b0}}, r_sum[UW-1]};

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_offset <= {n_sum_adj[UW-1], n_sum_adj[UW-1:1]};
            r_rtt_o  <= r_rtt;
            r_t3_o   <= r_t3_s5;
            r_t4_o   <= r_t4_s5;
        end
    end

    assign m_axis_tvalid = r_v[NSTG-1];
    assign m_axis_tdata  = {r_t4_o, r_t3_o, r_rtt_o, r_offset};

    // input back-pressure only when the output is full and stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

    // an accepted beat occupies the first stage next cycle
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[0])
        else $error("accepted beat lost at stage 1");

    // a stalled result keeps its offset
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !m_axis_tready) |=> (r_v[NSTG-1] && $stable(r_offset)))
        else $error("stalled result changed");

    // a full stage stuck behind a stall keeps its valid bit
    a_hold_s5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !w_rdy[4]) |=> (r_v[4] && $stable(r_sum)))
        else $error("stage 5 beat dropped under stall");

endmodule

`default_nettype wire
